// File: hdl/tcas_pkg.sv
// Shared constants, widths and divider interface types for the
// two-channel average scaler. No dependencies.
package tcas_pkg;

   // Averaging window per channel
   localparam int WINDOW_DEPTH = 8;

   // Field widths
   localparam int SAMPLE_W    = 10;
   localparam int SCALED_W    = 13;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   // Derived widths
   localparam int POS_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
   localparam int ADC_MAX   = 1023;
   localparam int TOT_W     = $clog2(WINDOW_DEPTH * ADC_MAX + 1);
   localparam int MEM_DEPTH = 2 ** (POS_W + 1);

   // Scaling constants
   localparam logic [SAMPLE_W-1:0] ADC_FULL    = SAMPLE_W'(ADC_MAX);
   localparam logic [SCALED_W-1:0] TEMP_SCALE  = SCALED_W'(5000);
   localparam logic [SCALED_W-1:0] LIGHT_SCALE = SCALED_W'(100);

   // mean * scale, up to 1023 * 5000
   localparam int PROD_W = $clog2(ADC_MAX * 5000 + 1);

   // Channel codes
   localparam logic CH_TEMP  = 1'b0;
   localparam logic CH_LIGHT = 1'b1;

   // Divider: dividend covers the running total, divisor covers the fill count
   localparam int DIV_W     = TOT_W;
   localparam int DVS_W     = CNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hdl/tcas_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tcas_pkg for widths and request/response types.
module tcas_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tcas_pkg::div_req_type div_req,
   output tcas_pkg::div_rsp_type div_rsp
);

   logic [tcas_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [tcas_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [tcas_pkg::DVS_W-1:0]     divisor_ff, divisor_in;
   logic [tcas_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [tcas_pkg::DVS_W:0]       shifted;
   logic [tcas_pkg::DVS_W:0]       diff;

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      done_in    = 1'b0;
      shifted    = {rem_ff, quo_ff[tcas_pkg::DIV_W-1]};
      diff       = shifted - {1'b0, divisor_ff};
      if (div_req.start) begin
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = tcas_pkg::DIV_CNT_W'(tcas_pkg::DIV_W);
      end else if (cnt_ff != '0) begin
         // no borrow means the trial subtract fits
         if (!diff[tcas_pkg::DVS_W]) begin
            rem_in = diff[tcas_pkg::DVS_W-1:0];
            quo_in = {quo_ff[tcas_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[tcas_pkg::DVS_W-1:0];
            quo_in = {quo_ff[tcas_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == tcas_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: hdl/two_channel_average_scaler.sv
// Two-channel moving average with warm-up, scaled to mV or percent.
// An accepted req beat passes through ST_UPDATE, ST_MEAN and ST_DRAIN to rsp_tvalid.
// One beat at a time: req_tready stays low until ST_DRAIN hands off; the mean pass
// through the shared divider dominates, the /1023 scaling folds in ST_DRAIN.
// Reset: synchronous, active high; clears state, rsp_tvalid, positions, fill flags and totals.
// Sample memory has no reset; an entry's value is only used after it is written.
module two_channel_average_scaler (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = raw_sample[9:0], zero pad [15:10]; tuser = cmd
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tcas_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   // response: tdata = scaled_value[12:0], zero pad [15:13]; tuser = channel_echo
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcas_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEAN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic                          cmd_ff, cmd_in;
   logic [tcas_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   // oldest entry of the ring, read at accept
   logic [tcas_pkg::SAMPLE_W-1:0] rd_ff;

   // per-channel ring state
   logic [tcas_pkg::POS_W-1:0] wpos_ff   [2];
   logic [tcas_pkg::POS_W-1:0] wpos_in   [2];
   logic                       filled_ff [2];
   logic                       filled_in [2];
   logic [tcas_pkg::TOT_W-1:0] total_ff  [2];
   logic [tcas_pkg::TOT_W-1:0] total_in  [2];

   // sample memory, {channel, position}
   logic [tcas_pkg::SAMPLE_W-1:0] mem [tcas_pkg::MEM_DEPTH];

   logic [tcas_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [tcas_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                             rsp_tuser_ff, rsp_tuser_in;

   tcas_pkg::div_req_type div_req;
   tcas_pkg::div_rsp_type div_rsp;

   // update datapath for the latched channel
   logic                          ch;
   logic [tcas_pkg::SAMPLE_W-1:0] old_sample;
   logic [tcas_pkg::TOT_W-1:0]    tot_new;
   logic [tcas_pkg::POS_W-1:0]    pos_next;
   logic                          fill_new;
   logic [tcas_pkg::CNT_W-1:0]    count;
   logic [tcas_pkg::SCALED_W-1:0] scale;
   logic                          req_fire;

   // constant /1023 on the product
   logic [tcas_pkg::SCALED_W-1:0]                    fold_q0;
   logic [tcas_pkg::SCALED_W-1:0]                    fold_r0;
   logic [tcas_pkg::SCALED_W-tcas_pkg::SAMPLE_W-1:0] fold_q1;
   logic [tcas_pkg::SAMPLE_W:0]                      fold_r1;
   logic [tcas_pkg::SCALED_W-1:0]                    scaled_mean;

   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      ch = cmd_ff;
      // the slot only holds a live sample once the ring has wrapped
      old_sample = filled_ff[ch] ? rd_ff : '0;
      tot_new    = total_ff[ch] - tcas_pkg::TOT_W'(old_sample)
                   + tcas_pkg::TOT_W'(sample_ff);
      pos_next   = (wpos_ff[ch] == tcas_pkg::POS_W'(tcas_pkg::WINDOW_DEPTH - 1))
                   ? '0 : wpos_ff[ch] + 1'b1;
      fill_new   = filled_ff[ch] || (pos_next == '0);
      // never zero: the new sample is already counted
      count      = fill_new ? tcas_pkg::CNT_W'(tcas_pkg::WINDOW_DEPTH)
                            : tcas_pkg::CNT_W'(pos_next);
      scale      = (ch == tcas_pkg::CH_LIGHT) ? tcas_pkg::LIGHT_SCALE
                                              : tcas_pkg::TEMP_SCALE;
      // 1023 = 1024 - 1: x = q0*1023 + (x mod 1024 + q0). Fold the remainder
      // once more; it then stays below 2*1023, so one compare finishes.
      fold_q0     = tcas_pkg::SCALED_W'(prod_ff >> tcas_pkg::SAMPLE_W);
      fold_r0     = tcas_pkg::SCALED_W'(prod_ff[tcas_pkg::SAMPLE_W-1:0]) + fold_q0;
      fold_q1     = fold_r0[tcas_pkg::SCALED_W-1:tcas_pkg::SAMPLE_W];
      fold_r1     = {1'b0, fold_r0[tcas_pkg::SAMPLE_W-1:0]}
                    + (tcas_pkg::SAMPLE_W + 1)'(fold_q1);
      scaled_mean = fold_q0 + tcas_pkg::SCALED_W'(fold_q1)
                    + tcas_pkg::SCALED_W'(fold_r1 >= {1'b0, tcas_pkg::ADC_FULL});
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sample_in     = sample_ff;
      wpos_in       = wpos_ff;
      filled_in     = filled_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      div_req       = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_tuser;
               sample_in = req_tdata[tcas_pkg::SAMPLE_W-1:0];
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            total_in[ch]     = tot_new;
            wpos_in[ch]      = pos_next;
            filled_in[ch]    = fill_new;
            div_req.start    = 1'b1;
            div_req.dividend = tot_new;
            div_req.divisor  = count;
            state_in         = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               // mean never exceeds full scale
               prod_in  = tcas_pkg::PROD_W'(div_rsp.quotient[tcas_pkg::SAMPLE_W-1:0])
                          * tcas_pkg::PROD_W'(scale);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // product holds until the output slot frees up
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = tcas_pkg::RSP_TDATA_W'(scaled_mean);
               rsp_tuser_in  = cmd_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         wpos_ff       <= '{default: '0};
         filled_ff     <= '{default: 1'b0};
         total_ff      <= '{default: '0};
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         wpos_ff       <= wpos_in;
         filled_ff     <= filled_in;
         total_ff      <= total_in;
      end
      cmd_ff       <= cmd_in;
      sample_ff    <= sample_in;
      prod_ff      <= prod_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // sample memory: read the slot about to be overwritten, write during update
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= mem[{req_tuser, wpos_ff[req_tuser]}];
      end
      if (state_ff == ST_UPDATE) begin
         mem[{cmd_ff, wpos_ff[cmd_ff]}] <= sample_ff;
      end
   end

   tcas_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// File: hdl/tcas_checker.sv
// Port-level checks for two_channel_average_scaler, attached by bind.
// Depends on tcas_pkg for widths and channel codes.
module tcas_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tcas_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // one item at a time: busy right after an accepted request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // light results are percent
   a_light_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tcas_pkg::CH_LIGHT) |->
         rsp_tdata[tcas_pkg::SCALED_W-1:0] <= tcas_pkg::SCALED_W'(100))
      else $error("light result above 100");

   // every result stays within 5000 (temperature full scale), pad bits zero
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= tcas_pkg::RSP_TDATA_W'(5000))
      else $error("result above 5000 or pad bits set");

endmodule

bind two_channel_average_scaler tcas_checker u_tcas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/tcas_reading_checker.sv
`timescale 1ns / 100ps
// Scoreboard for two_channel_average_scaler: keeps its own per-channel sample rings,
// predicts the scaled reading of every req beat and checks rsp beats in order.
// Depends on tcas_pkg.
module tcas_reading_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tcas_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tcas_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tuser,
   output int                               outstanding,
   output int                               error_count
);

   typedef struct packed {
      logic [tcas_pkg::SCALED_W-1:0] scaled;
      logic                          channel;
   } reading_type;

   // per-channel window state
   logic [tcas_pkg::SAMPLE_W-1:0] ring [2][tcas_pkg::WINDOW_DEPTH];
   int unsigned                   wpos [2];
   bit                            filled [2];
   logic [tcas_pkg::TOT_W-1:0]    total [2];

   reading_type expected_readings [$];
   int          errors = 0;

   // push one sample into the channel's window, return the scaled mean
   function automatic reading_type average_and_scale(
      input logic                          ch,
      input logic [tcas_pkg::SAMPLE_W-1:0] smp);
      int unsigned slot;
      int unsigned count;
      int unsigned mean;
      int unsigned factor;
      reading_type r;
      slot = wpos[ch];
      if (filled[ch])
         total[ch] = total[ch] - ring[ch][slot];
      ring[ch][slot] = smp;
      total[ch] = total[ch] + smp;
      slot = (slot + 1) % tcas_pkg::WINDOW_DEPTH;
      wpos[ch] = slot;
      if (slot == 0)
         filled[ch] = 1'b1;
      // warm-up: only the entries written so far count
      count = filled[ch] ? tcas_pkg::WINDOW_DEPTH : slot;
      if (count == 0)
         count = 1;
      mean = total[ch] / count;
      factor = (ch == tcas_pkg::CH_LIGHT) ? tcas_pkg::LIGHT_SCALE : tcas_pkg::TEMP_SCALE;
      r.scaled = tcas_pkg::SCALED_W'((mean * factor) / tcas_pkg::ADC_MAX);
      r.channel = ch;
      return r;
   endfunction

   task automatic note_error(input string what);
      errors++;
      if (errors <= 10)
         $display("[%0t] rsp mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            wpos[c] = 0;
            filled[c] = 1'b0;
            total[c] = '0;
         end
         expected_readings.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_readings.push_back(
               average_and_scale(req_tuser, req_tdata[tcas_pkg::SAMPLE_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got.scaled = rsp_tdata[tcas_pkg::SCALED_W-1:0];
            got.channel = rsp_tuser;
            if (expected_readings.size() == 0) begin
               note_error($sformatf("unexpected beat scaled=%0d channel=%0d",
                                    got.scaled, got.channel));
            end else begin
               want = expected_readings.pop_front();
               if (got.scaled !== want.scaled || got.channel !== want.channel)
                  note_error($sformatf("expected scaled=%0d channel=%0d, got %0d / %0d",
                                       want.scaled, want.channel,
                                       got.scaled, got.channel));
            end
         end
      end
      outstanding <= expected_readings.size();
      error_count <= errors;
   end

endmodule

// File: tb/tb_two_channel_average_scaler.sv
`timescale 1ns / 100ps
// Top-level testbench for two_channel_average_scaler: drives req beats in bursts,
// stalls rsp on rotating patterns, and gives the verdict from tcas_reading_checker.
// Depends on tcas_pkg, the DUT and tb/tcas_reading_checker.sv.
module tb_two_channel_average_scaler;

   // watchdog: cycles without any beat
   localparam int IDLE_LIMIT   = 3000;
   // extra cycles after the last reading
   localparam int TAIL_CYCLES  = 64;
   localparam int RANDOM_BEATS = 550;

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_WINDOWED} ready_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tcas_pkg::REQ_TDATA_W-1:0] req_tdata = '0;   // raw_sample[9:0], zero pad above
   logic                             req_tuser = tcas_pkg::CH_TEMP;  // cmd
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tcas_pkg::RSP_TDATA_W-1:0] rsp_tdata;        // scaled_value[12:0], zero pad above
   logic                             rsp_tuser;        // channel_echo

   int             outstanding;
   int             error_count;
   int             idle_cycles = 0;
   int             burst_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned    ready_tick = 0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   two_channel_average_scaler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tcas_reading_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .outstanding (outstanding),
      .error_count (error_count)
   );

   // Receiver: the backpressure pattern is redrawn at random from three modes.
   // Windowed mode holds ready low for most of each period, so a finished reading
   // sits on the output for a while at every phase of the next computation.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (ready_tick % 400 == 399)
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready <= ((ready_tick % 47) < 12);
         end
      endcase
   end

   // Watchdog: any beat on either side restarts the count
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // One req beat. Bursts of 1..12 beats; between bursts valid drops for a
   // random gap (none a quarter of the time, so some bursts run back to back).
   // Returns at the edge where the beat was taken.
   task automatic send_sample(input logic ch, input logic [tcas_pkg::SAMPLE_W-1:0] smp);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= ch;
      req_tdata  <= tcas_pkg::REQ_TDATA_W'(smp);
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
   endtask

   // Hold the sender off until every predicted reading has come back.
   // The first edge lets the checker's count catch up with the last beat.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic                          ch;
      logic [tcas_pkg::SAMPLE_W-1:0] smp;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Temperature: zero, full scale and alternating bit patterns during
      // warm-up, then a full window of 1023 so the ring wraps and the mean
      // reaches full scale (exactly 5000 mV).
      send_sample(tcas_pkg::CH_TEMP, 10'd0);
      send_sample(tcas_pkg::CH_TEMP, 10'd1023);
      send_sample(tcas_pkg::CH_TEMP, 10'h2AA);
      send_sample(tcas_pkg::CH_TEMP, 10'h155);
      repeat (tcas_pkg::WINDOW_DEPTH) send_sample(tcas_pkg::CH_TEMP, 10'd1023);

      // Light: full window of 1023 -> exactly 100 %, then small values that
      // replace the oldest entries after the wrap.
      repeat (tcas_pkg::WINDOW_DEPTH) send_sample(tcas_pkg::CH_LIGHT, 10'd1023);
      send_sample(tcas_pkg::CH_LIGHT, 10'd0);
      send_sample(tcas_pkg::CH_LIGHT, 10'd1);
      wait_until_drained();

      // Random part: runs on one channel with occasional switches, so windows
      // fill and wrap on both channels interleaved. Samples lean toward the
      // ends of the range now and then.
      ch = tcas_pkg::CH_TEMP;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(0, 3) == 0)
            ch = ~ch;
         case ($urandom_range(0, 9))
            0: begin
               smp = tcas_pkg::SAMPLE_W'($urandom_range(0, 7));
            end
            1: begin
               smp = tcas_pkg::SAMPLE_W'($urandom_range(1016, 1023));
            end
            default: begin
               smp = tcas_pkg::SAMPLE_W'($urandom_range(0, 1023));
            end
         endcase
         send_sample(ch, smp);
         if (n == 200 || n == 420)
            wait_until_drained();
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
